@@ design/lzwe_pkg.sv @@
// Shared types and constants for the LZW byte encoder.
package lzwe_pkg;

  localparam int BYTE_W        = 8;
  localparam int OUT_W         = 12;
  localparam int OUT_TDATA_W   = 16;
  localparam int FIRST_FREE    = 256;
  localparam int CODE_BITS_DEF = 12;

  // One result transaction waiting for the master side.
  typedef struct packed {
    logic             final_code;
    logic [OUT_W-1:0] phrase_code;
  } out_item_t;

  // Broadcast strobes from the sequencer to every dictionary cell.
  typedef struct packed {
    logic load;   // compare the key and restart the hit chain
    logic write;  // store the key in the cell chosen by wr_addr
  } cell_ctrl_t;

endpackage

@@ design/lzwe_cell.sv @@
// One dictionary cell: stores a (prefix, byte) pair and passes hit bits toward cell 0.
module lzwe_cell #(
  parameter int CODE_BITS = lzwe_pkg::CODE_BITS_DEF,
  parameter int INDEX     = 0
) (
  input  logic                        clk,
  input  lzwe_pkg::cell_ctrl_t        ctrl,
  input  logic [CODE_BITS-1:0]        key_prefix,
  input  logic [lzwe_pkg::BYTE_W-1:0] key_byte,
  input  logic [CODE_BITS-1:0]        wr_addr,
  input  logic                        hit_in,
  output logic                        hit_out
);
  import lzwe_pkg::*;

  logic [CODE_BITS-1:0] prefix;
  logic [BYTE_W-1:0]    sym;
  logic                 hit;

  always_ff @(posedge clk) begin
    if (ctrl.write && (wr_addr == CODE_BITS'(INDEX))) begin
      prefix <= key_prefix;
      sym    <= key_byte;
    end
  end

  // Load the compare result, otherwise shift the neighbor's bit down the chain.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hit <= (prefix == key_prefix) && (sym == key_byte);
    end else begin
      hit <= hit_in;
    end
  end

  assign hit_out = hit;

endmodule

@@ design/lzwe_out_fifo.sv @@
// Four-entry result queue between the sequencer and the master stream port.
module lzwe_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lzwe_pkg::out_item_t push_item,
  output logic                room,
  output logic                valid,
  input  logic                ready,
  output lzwe_pkg::out_item_t item
);
  import lzwe_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop   = valid && ready;
  assign valid = (count != '0);
  assign room  = (count <= CNT_W'(DEPTH - 2));
  assign item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/lzw_byte_encoder.sv @@
// Top level of the LZW byte encoder: sequencer, chain of dictionary cells, result queue.
// A stream's first byte starts the phrase; each later byte goes to S_LOAD and, unless the
//   dictionary is empty, S_SCAN over the entries in use (at most 2^CODE_BITS - 256).
// The hit bits leave the cell chain one cell per cycle, so the scan length sets the rate.
// A hit ends a scan early, and S_FLUSH sends a stream's final code; results wait in a
//   four-entry queue. Synchronous active-high reset empties the queue and the dictionary.
module lzw_byte_encoder #(
  parameter int CODE_BITS = lzwe_pkg::CODE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Slave side: one transaction per input byte.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lzwe_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  logic                             s_axis_tlast,  // end_of_stream
  // Master side: one transaction per emitted code.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [lzwe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [11:0] phrase_code, rest zero
  output logic                             m_axis_tlast   // final_code
);
  import lzwe_pkg::*;

  // Cell i holds dictionary code 256 + i.
  localparam int NCELLS = (1 << CODE_BITS) - FIRST_FREE;
  localparam int CNT_W  = CODE_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,   // wait for a byte
    S_LOAD,   // compare the key in every cell at once
    S_SCAN,   // watch hit bits arrive from the chain, one cell per cycle
    S_FLUSH   // emit the final code and reset the dictionary
  } state_t;

  state_t               state;
  logic [CODE_BITS-1:0] cur;          // current phrase code
  logic [CNT_W-1:0]     next_free;    // next code to assign
  logic                 active;       // a byte of this stream has been seen
  logic [CODE_BITS-1:0] key_prefix;
  logic [BYTE_W-1:0]    byte_r;
  logic                 last_r;
  logic [CODE_BITS-1:0] scan_idx;     // cell whose hit bit is at the chain output

  logic [CNT_W-1:0]     used;
  logic                 dict_empty;
  logic                 dict_full;
  logic                 last_cell;
  logic                 hit0;
  logic                 hit_now;
  logic                 miss_now;
  logic                 done;
  logic                 accept;
  logic                 room;
  logic                 push;
  out_item_t            push_item;
  out_item_t            out_item;
  cell_ctrl_t           ctrl;
  logic [CODE_BITS-1:0] wr_addr;
  logic [CODE_BITS-1:0] hit_code;
  logic                 hits [NCELLS+1];

  // Dictionary bookkeeping.
  assign used       = next_free - CNT_W'(FIRST_FREE);
  assign dict_empty = (used == '0);
  assign dict_full  = next_free[CODE_BITS];
  assign wr_addr    = used[CODE_BITS-1:0];
  assign last_cell  = ((CNT_W'(scan_idx) + CNT_W'(1)) == used);
  assign hit_code   = CODE_BITS'(FIRST_FREE) + scan_idx;

  // Only cells below the fill count are ever looked at: the scan stops at the last one.
  assign hit0     = hits[0];
  assign hit_now  = (state == S_SCAN) && hit0;
  assign miss_now = ((state == S_LOAD) && dict_empty) ||
                    ((state == S_SCAN) && !hit0 && last_cell);
  assign done     = hit_now || miss_now;

  // Take a byte only when the queue can hold both codes that it may cause.
  assign s_axis_tready = (state == S_IDLE) && room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ctrl.load  = (state == S_LOAD) && !dict_empty;
  assign ctrl.write = miss_now && !dict_full;

  // A miss emits the old phrase; the flush emits whatever phrase remains.
  assign push                  = miss_now || (state == S_FLUSH);
  assign push_item.phrase_code = OUT_W'(cur);
  assign push_item.final_code  = (state == S_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      next_free <= CNT_W'(FIRST_FREE);
      active    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            byte_r     <= s_axis_tdata;
            last_r     <= s_axis_tlast;
            key_prefix <= cur;
            if (!active) begin
              // First byte of a stream just starts the phrase.
              cur    <= CODE_BITS'(s_axis_tdata);
              active <= 1'b1;
              state  <= s_axis_tlast ? S_FLUSH : S_IDLE;
            end else begin
              state <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          scan_idx <= '0;
          // An empty dictionary resolves right here as a miss.
          if (!dict_empty) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + CODE_BITS'(1);
        end
        S_FLUSH: begin
          cur       <= '0;
          next_free <= CNT_W'(FIRST_FREE);
          active    <= 1'b0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      // Resolved: a hit grows the phrase; a miss restarts it and adds the pair if not full.
      if (done) begin
        cur   <= hit_now ? hit_code : CODE_BITS'(byte_r);
        state <= last_r ? S_FLUSH : S_IDLE;
        if (ctrl.write) begin
          next_free <= next_free + CNT_W'(1);
        end
      end
    end
  end

  // Cell chain: hit bits travel from the high cells toward cell 0.
  assign hits[NCELLS] = 1'b0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    lzwe_cell #(
      .CODE_BITS(CODE_BITS),
      .INDEX    (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key_prefix(key_prefix),
      .key_byte  (byte_r),
      .wr_addr   (wr_addr),
      .hit_in    (hits[i+1]),
      .hit_out   (hits[i])
    );
  end

  lzwe_out_fifo u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .room     (room),
    .valid    (m_axis_tvalid),
    .ready    (m_axis_tready),
    .item     (out_item)
  );

  assign m_axis_tdata = OUT_TDATA_W'(out_item.phrase_code);
  assign m_axis_tlast = out_item.final_code;

endmodule

@@ design/lzwe_checker.sv @@
// Port-level checks for the LZW byte encoder, bound to the top level.
module lzwe_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [lzwe_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import lzwe_pkg::*;

  // Hold a stalled result transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed or dropped");

  // Codes never use the padding bits.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0))
    else $error("padding bits of result set");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // The last byte of a stream blocks input while the final code is flushed.
  a_flush_stall: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken during flush");

  // No result carrying the final mark is valid when reset has just been released.
  a_no_early_final: assert property (@(posedge clk) disable iff (rst)
    ($past(rst) && !rst) |-> !(m_axis_tvalid && m_axis_tlast))
    else $error("final code without input");

endmodule

bind lzw_byte_encoder lzwe_checker u_lzwe_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

@@ tb/tb.sv @@
// Self-checking testbench for the LZW byte encoder: stream stimulus, code predictor, checker.
module tb;
  import lzwe_pkg::*;

  localparam int DICT_SIZE    = 1 << CODE_BITS_DEF;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_BYTES  = 212;

  // Stream content styles.
  typedef enum int {
    NOISE_BYTES,
    SMALL_ALPHABET,
    REPEATED_WORD
  } stream_style_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_txn_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [BYTE_W-1:0]      s_axis_tdata  = '0;  // [7:0] data_byte
  logic                   s_axis_tlast  = 1'b0;  // end_of_stream
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [11:0] phrase_code, rest zero
  logic                   m_axis_tlast;  // final_code

  lzw_byte_encoder #(.CODE_BITS(CODE_BITS_DEF)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  byte_txn_t  pending_bytes[$];
  out_item_t  expected_codes[$];
  byte_txn_t  drive_txn;
  int         idle_pct      = 0;
  int         stall_pct     = 0;
  int         byte_count    = 0;
  int         stream_count  = 0;
  int         code_count    = 0;
  int         final_count   = 0;
  int         error_count   = 0;
  int         max_dict_used = 0;
  longint     cycle_count   = 0;

  // Predictor state: dictionary of (prefix, suffix byte) pairs and the phrase in progress.
  logic [OUT_W-1:0]  dict_prefix [DICT_SIZE];
  logic [BYTE_W-1:0] dict_suffix [DICT_SIZE];
  logic [OUT_W-1:0]  cur_code    = '0;
  int                next_code   = FIRST_FREE;
  logic              phrase_on   = 1'b0;

  initial forever #4 clk = ~clk;

  // Advance the encoder model by one byte and queue the codes it emits.
  function automatic void encode_byte(input logic [BYTE_W-1:0] b, input logic last);
    int        hit;
    int        k;
    out_item_t item;
    hit = -1;
    if (!phrase_on) begin
      cur_code  = OUT_W'(b);
      phrase_on = 1'b1;
    end else begin
      for (k = FIRST_FREE; k < next_code && k < DICT_SIZE; k++) begin
        if (hit < 0 && dict_prefix[k] == cur_code && dict_suffix[k] == b) hit = k;
      end
      if (hit >= 0) begin
        cur_code = OUT_W'(hit);
      end else begin
        // Miss: emit the matched phrase, learn the new pair while room is left.
        item.phrase_code = cur_code;
        item.final_code  = 1'b0;
        expected_codes.insert(expected_codes.size(), item);
        if (next_code < DICT_SIZE) begin
          dict_prefix[next_code] = cur_code;
          dict_suffix[next_code] = b;
          next_code++;
        end
        cur_code = OUT_W'(b);
      end
    end
    if (next_code - FIRST_FREE > max_dict_used) max_dict_used = next_code - FIRST_FREE;
    if (last) begin
      // Flush the phrase in progress and forget the dictionary.
      item.phrase_code = cur_code;
      item.final_code  = 1'b1;
      expected_codes.insert(expected_codes.size(), item);
      cur_code  = '0;
      next_code = FIRST_FREE;
      phrase_on = 1'b0;
    end
  endfunction

  function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic last);
    byte_txn_t t;
    t.data = b;
    t.last = last;
    pending_bytes.insert(pending_bytes.size(), t);
  endfunction

  // Queue one complete stream; the last byte carries the end mark.
  task automatic gen_stream(input int len, input stream_style_t style);
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] word [6];
    logic [BYTE_W-1:0] b;
    int                spread;
    int                word_len;
    int                i;
    base     = BYTE_W'($urandom_range(255));
    spread   = $urandom_range(3);
    word_len = $urandom_range(2, 6);
    for (i = 0; i < 6; i++) word[i] = BYTE_W'($urandom_range(255));
    for (i = 0; i < len; i++) begin
      case (style)
        NOISE_BYTES:    b = BYTE_W'($urandom_range(255));
        SMALL_ALPHABET: b = base ^ BYTE_W'($urandom_range(spread));
        default: begin
          // Mostly a repeating word, now and then a corrupted byte to break the match.
          b = word[i % word_len];
          if ($urandom_range(19) == 0) b = BYTE_W'($urandom_range(255));
        end
      endcase
      push_byte(b, i == len - 1);
    end
    stream_count++;
  endtask

  // Queue streams totaling exactly n_bytes; the last stream is cut to fit.
  task automatic gen_random_streams(input int n_bytes);
    int            queued;
    int            len;
    int            r;
    stream_style_t style;
    queued = 0;
    while (queued < n_bytes) begin
      r = $urandom_range(99);
      if (r < 8)       len = 1;
      else if (r < 93) len = $urandom_range(2, 40);
      else             len = $urandom_range(120, 300);
      if (len > n_bytes - queued) len = n_bytes - queued;
      r = $urandom_range(99);
      if (r < 15)      style = NOISE_BYTES;
      else if (r < 55) style = SMALL_ALPHABET;
      else             style = REPEATED_WORD;
      gen_stream(len, style);
      queued += len;
    end
  endtask

  // Hold until every queued byte is accepted and every predicted code has come out.
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_codes.size() != 0)
      @(negedge clk);
  endtask

  // Driver: present the next byte unless idling; hold a byte until its transaction completes.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          drive_txn = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= drive_txn.data;
          s_axis_tlast  <= drive_txn.last;
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= BYTE_W'($urandom);
          s_axis_tlast  <= 1'($urandom);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: check each output transaction, then feed each accepted byte to the predictor.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        code_count++;
        if (m_axis_tlast) final_count++;
        if (expected_codes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected code, expected none actual code %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          exp_item = expected_codes.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== exp_item.phrase_code) begin
            error_count++;
            $display("%0t: phrase_code mismatch, expected %h actual %h",
                     $time, exp_item.phrase_code, m_axis_tdata[OUT_W-1:0]);
          end
          if (m_axis_tlast !== exp_item.final_code) begin
            error_count++;
            $display("%0t: final_code mismatch, expected %b actual %b",
                     $time, exp_item.final_code, m_axis_tlast);
          end
          if (m_axis_tdata[OUT_TDATA_W-1:OUT_W] !== '0) begin
            error_count++;
            $display("%0t: tdata padding mismatch, expected 0 actual %h",
                     $time, m_axis_tdata[OUT_TDATA_W-1:OUT_W]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        byte_count++;
        encode_byte(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d codes still expected",
               $time, cycle_count, expected_codes.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: one-byte streams at both byte extremes.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // Alternating pair: misses, then a hit on a learned pair, then misses up to the end byte.
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h43, 1'b1);
    // Run of one byte: phrases grow along the run, end byte is a hit.
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'h5A, 1'b1);
    // Extremes interleaved, then the same bytes again to show the dictionary was cleared.
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    stream_count += 6;
    wait_drained();

    // Random streams under each idling pattern; drain between phases.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      gen_random_streams(PHASE_BYTES / 2);
      // Pause the sender mid-phase until all codes are out.
      wait_drained();
      gen_random_streams(PHASE_BYTES - PHASE_BYTES / 2);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_codes.size() != 0) begin
      error_count++;
      $display("%0t: %0d codes never arrived", $time, expected_codes.size());
    end
    $display("Encoded %0d bytes in %0d streams under four idle/stall patterns.",
             byte_count, stream_count);
    $display("Checked %0d codes (%0d stream flushes), dictionary reached %0d entries.",
             code_count, final_count, max_dict_used);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ lzw_byte_encoder.f @@
design/lzwe_pkg.sv
design/lzwe_cell.sv
design/lzwe_out_fifo.sv
design/lzw_byte_encoder.sv
design/lzwe_checker.sv
tb/tb.sv
